/* sv/mfd_pkg.sv */
// shared types and constants of the motion-jpeg frame deframer
// no dependencies

package mfd_pkg;

	localparam int unsigned LEN_W = 22;

	localparam logic [7:0] MARK_LEAD = 8'hFF;
	localparam logic [7:0] MARK_SOI  = 8'hD8;
	localparam logic [7:0] MARK_EOI  = 8'hD9;

	localparam logic [LEN_W-1:0] MAX_FRAME_RESET = 22'h200000;

	typedef logic [1:0] status_t;

	localparam status_t ST_BYTE    = 2'd0;
	localparam status_t ST_TRUNC   = 2'd1;
	localparam status_t ST_OVER    = 2'd2;
	localparam status_t ST_NOFRAME = 2'd3;

	// one queued action: a single result, or the start marker pair when dbl is set
	typedef struct packed {
		logic    dbl;
		logic [7:0] data;
		status_t status;
		logic    last;
	} op_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

endpackage

/* sv/mfd_front.sv */
// front part: accepts input items, tracks hunting and frame state, queues actions
// depends on mfd_pkg

module mfd_front (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_cmd,
	input  logic [7:0]               in_data,
	input  logic [mfd_pkg::LEN_W-1:0] max_frame,
	input  mfd_pkg::q_stat_t         q_stat,
	output logic                     in_ready,
	output logic                     push,
	output mfd_pkg::op_t             push_op
);
	import mfd_pkg::*;

	logic             in_frame_q;
	logic             prev_ff_q;
	logic [LEN_W-1:0] len_q;
	logic             in_frame_d;
	logic             prev_ff_d;
	logic [LEN_W-1:0] len_d;
	logic             acc;
	logic             emit;

	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;
	assign push     = acc && emit;

	always_comb begin
		in_frame_d = in_frame_q;
		prev_ff_d  = prev_ff_q;
		len_d      = len_q;
		emit       = 1'b0;
		push_op    = '{dbl: 1'b0, data: 8'h00, status: ST_BYTE, last: 1'b0};
		priority if (in_cmd) begin
			emit           = 1'b1;
			push_op.status = (in_frame_q && len_q > LEN_W'(2)) ? ST_TRUNC : ST_NOFRAME;
			push_op.last   = 1'b1;
			in_frame_d     = 1'b0;
			prev_ff_d      = 1'b0;
			len_d          = '0;
		end else if (!in_frame_q) begin
			if (prev_ff_q && in_data == MARK_SOI) begin
				emit         = 1'b1;
				push_op.dbl  = 1'b1;
				push_op.data = MARK_SOI;
				in_frame_d   = 1'b1;
				prev_ff_d    = 1'b0;
				len_d        = LEN_W'(2);
			end else begin
				prev_ff_d = (in_data == MARK_LEAD);
			end
		end else if (len_q >= max_frame) begin
			emit           = 1'b1;
			push_op.status = ST_OVER;
			push_op.last   = 1'b1;
			in_frame_d     = 1'b0;
			prev_ff_d      = 1'b0;
			len_d          = '0;
		end else begin
			emit         = 1'b1;
			push_op.data = in_data;
			if (prev_ff_q && in_data == MARK_EOI) begin
				push_op.last = 1'b1;
				in_frame_d   = 1'b0;
				prev_ff_d    = 1'b0;
				len_d        = '0;
			end else begin
				prev_ff_d = (in_data == MARK_LEAD);
				len_d     = len_q + LEN_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			prev_ff_q  <= 1'b0;
			len_q      <= '0;
		end else if (acc) begin
			in_frame_q <= in_frame_d;
			prev_ff_q  <= prev_ff_d;
			len_q      <= len_d;
		end
	end

endmodule

/* sv/mfd_queue.sv */
// short action queue between the front and back parts
// depends on mfd_pkg

module mfd_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  mfd_pkg::op_t     push_op,
	input  logic             pop,
	output mfd_pkg::op_t     head_op,
	output mfd_pkg::q_stat_t q_stat
);
	import mfd_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	op_t           mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push;
	logic          do_pop;

	assign q_stat.full     = (cnt_q == CW'(DEPTH));
	assign q_stat.nonempty = (cnt_q != '0);
	assign do_push         = push && !q_stat.full;
	assign do_pop          = pop && q_stat.nonempty;
	assign head_op         = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_op;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* sv/mfd_back.sv */
// back part: expands queued actions into results and holds the output register
// depends on mfd_pkg

module mfd_back (
	input  logic             clk,
	input  logic             arst_n,
	input  mfd_pkg::op_t     head_op,
	input  mfd_pkg::q_stat_t q_stat,
	output logic             pop,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       res_byte,
	output mfd_pkg::status_t out_status,
	output logic             out_last
);
	import mfd_pkg::*;

	logic       valid_q;
	logic       second_q;
	logic [7:0] data_q;
	status_t    status_q;
	logic       last_q;
	logic       load;
	logic       lead_half;

	assign load      = (!valid_q || out_ready) && q_stat.nonempty;
	assign lead_half = head_op.dbl && !second_q;
	assign pop       = load && !lead_half;

	assign out_valid  = valid_q;
	assign res_byte   = data_q;
	assign out_status = status_q;
	assign out_last   = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q  <= 1'b1;
				second_q <= lead_half;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q   <= lead_half ? MARK_LEAD : head_op.data;
			status_q <= head_op.status;
			last_q   <= head_op.last;
		end
	end

endmodule

/* sv/mjpeg_frame_deframer_top.sv */
// top level of the motion-jpeg frame deframer
// depends on mfd_pkg, mfd_front, mfd_queue, mfd_back

// Takes one stream byte per cycle while s_tready is high (s_tuser high marks end
// of stream) and gives out JPEG frames from start marker to end marker, m_tlast on
// the end marker or a status result. An item completing a start marker yields two
// results from one action queue entry, which the output side drains one after the
// other. A result passes through the action queue and the output register before
// it is presented on m_tvalid. Input is taken every cycle unless the action queue
// holds QUEUE_DEPTH entries. The output side's one result per cycle while m_tready
// is high sets the peak.

module mjpeg_frame_deframer_top #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mfd_pkg::LEN_W-1:0] cfg_wdata,   // max_frame_bytes
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,     // data_byte
	input  logic                      s_tuser,     // cmd
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,     // out_byte
	output logic [1:0]                m_tuser,     // status
	output logic                      m_tlast
);
	import mfd_pkg::*;

	logic [LEN_W-1:0] max_frame_q;
	logic             push;
	op_t              push_op;
	op_t              head_op;
	logic             pop;
	q_stat_t          q_stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_q <= MAX_FRAME_RESET;
		end else if (cfg_we) begin
			max_frame_q <= cfg_wdata;
		end
	end

	mfd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_cmd    (s_tuser),
		.in_data   (s_tdata),
		.max_frame (max_frame_q),
		.q_stat    (q_stat),
		.in_ready  (s_tready),
		.push      (push),
		.push_op   (push_op)
	);

	mfd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.pop     (pop),
		.head_op (head_op),
		.q_stat  (q_stat)
	);

	mfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_op    (head_op),
		.q_stat     (q_stat),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.res_byte   (m_tdata),
		.out_status (m_tuser),
		.out_last   (m_tlast)
	);

endmodule

/* sv/mfd_checker.sv */
// port-level checks of the motion-jpeg frame deframer, bound to the top level
// depends on mfd_pkg and mjpeg_frame_deframer_top

module mfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        cfg_we,
	input logic [21:0] cfg_wdata,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [7:0]  s_tdata,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic [1:0]  m_tuser,
	input logic        m_tlast
);
	import mfd_pkg::*;

	// status results always close a frame or stream
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_BYTE |-> m_tlast)
		else $error("status result without tlast");

	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != ST_BYTE |-> m_tdata == 8'h00)
		else $error("status result with nonzero data");

	// a frame only ends on the end marker byte
	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_BYTE && m_tlast |-> m_tdata == MARK_EOI)
		else $error("frame ended on a byte other than the end marker");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("stalled output transfer changed");

endmodule

bind mjpeg_frame_deframer_top mfd_checker u_mfd_checker (.*);
